FILE: sv/ppm_pkg.sv
// shared types and constants of the ppm frame decoder
package ppm_pkg;

   // channel store size used by default
   localparam int MAX_CHANNELS_DEFAULT = 12;

   // configuration register indexes
   localparam logic [2:0] REG_FRAME_GAP_MIN   = 3'd0;
   localparam logic [2:0] REG_PULSE_MIN       = 3'd1;
   localparam logic [2:0] REG_PULSE_MAX       = 3'd2;
   localparam logic [2:0] REG_LOCK_FRAMES     = 3'd3;
   localparam logic [2:0] REG_MIN_FRAME_CHANS = 3'd4;
   localparam logic [2:0] REG_MAX_FRAME_PULSE = 3'd5;

   // register reset values
   localparam logic [15:0] FRAME_GAP_MIN_RST   = 16'd2900;
   localparam logic [15:0] PULSE_MIN_RST       = 16'd800;
   localparam logic [15:0] PULSE_MAX_RST       = 16'd2500;
   localparam logic [3:0]  LOCK_FRAMES_RST     = 4'd4;
   localparam logic [4:0]  MIN_FRAME_CHANS_RST = 5'd4;
   localparam logic [4:0]  MAX_FRAME_PULSE_RST = 5'd20;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

endpackage

FILE: sv/ppm_frame_decoder.sv
// ppm frame decoder top level: interval classification, channel store and frame readout
//
// Each req transfer carries one measured interval between rising edges of a PPM
// signal. Pulse intervals are written into an on-chip channel store while a frame
// is open; a frame gap closes the frame and, once enough equal-length frames have
// been seen (lock_frames), the stored channels are read back and sent as one rsp
// transfer per channel, tlast on the final one. A frame gap that releases a frame
// keeps req_tready low while its channels are read out, which rsp_tready stalls
// can stretch. The store has a registered read port: one entry is read per cycle
// unless rsp_tready stalls, the first read issued with the gap transfer. The rsp
// output register lets the next interval be taken while the final channel still
// waits. The store needs no clearing after reset: every delivered entry was
// written in the frame being delivered.
module ppm_frame_decoder #(
   parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // interval input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] interval_us
   // channel output stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] chan_index, [19:4] chan_width_us,
                                    // [23:20] frame_channels
   output logic        rsp_tlast,   // last_in_frame
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [4:0] MAX_CH5 = 5'(MAX_CHANNELS);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [15:0] gap_min_ff, pulse_min_ff, pulse_max_ff;
   logic [3:0]  lock_frames_ff;
   logic [4:0]  min_chans_ff, max_pulses_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_min_ff     <= ppm_pkg::FRAME_GAP_MIN_RST;
         pulse_min_ff   <= ppm_pkg::PULSE_MIN_RST;
         pulse_max_ff   <= ppm_pkg::PULSE_MAX_RST;
         lock_frames_ff <= ppm_pkg::LOCK_FRAMES_RST;
         min_chans_ff   <= ppm_pkg::MIN_FRAME_CHANS_RST;
         max_pulses_ff  <= ppm_pkg::MAX_FRAME_PULSE_RST;
      end else if (csr_write) begin
         case (csr_index)
            ppm_pkg::REG_FRAME_GAP_MIN:   gap_min_ff     <= csr_pwdata[15:0];
            ppm_pkg::REG_PULSE_MIN:       pulse_min_ff   <= csr_pwdata[15:0];
            ppm_pkg::REG_PULSE_MAX:       pulse_max_ff   <= csr_pwdata[15:0];
            ppm_pkg::REG_LOCK_FRAMES:     lock_frames_ff <= csr_pwdata[3:0];
            ppm_pkg::REG_MIN_FRAME_CHANS: min_chans_ff   <= csr_pwdata[4:0];
            ppm_pkg::REG_MAX_FRAME_PULSE: max_pulses_ff  <= csr_pwdata[4:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ppm_pkg::REG_FRAME_GAP_MIN:   csr_prdata = {16'd0, gap_min_ff};
         ppm_pkg::REG_PULSE_MIN:       csr_prdata = {16'd0, pulse_min_ff};
         ppm_pkg::REG_PULSE_MAX:       csr_prdata = {16'd0, pulse_max_ff};
         ppm_pkg::REG_LOCK_FRAMES:     csr_prdata = {28'd0, lock_frames_ff};
         ppm_pkg::REG_MIN_FRAME_CHANS: csr_prdata = {27'd0, min_chans_ff};
         ppm_pkg::REG_MAX_FRAME_PULSE: csr_prdata = {27'd0, max_pulses_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // frame tracking state
   // ---------------------------------------------------------------
   ppm_pkg::state_type state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic [4:0]    pulse_cnt_ff, pulse_cnt_in;
   logic [4:0]    prev_cnt_ff, prev_cnt_in;
   logic [3:0]    match_ff, match_in;
   logic [4:0]    deliver_cnt_ff, deliver_cnt_in;  // channels in the frame being read out
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;

   logic [15:0] interval;
   logic        accept, is_gap, is_pulse, same_len, emit, store_wr;
   logic [4:0]  clamp_cnt;
   logic        slot_free, load, last_chan, rd_en;
   logic [AW-1:0] rd_addr;

   assign interval = req_tdata;
   assign accept   = req_tvalid & req_tready;
   assign is_gap   = interval >= gap_min_ff;
   assign is_pulse = (pulse_cnt_ff < max_pulses_ff) &&
                     (interval >= pulse_min_ff) && (interval <= pulse_max_ff);
   assign same_len = pulse_cnt_ff == prev_cnt_ff;
   assign clamp_cnt = (pulse_cnt_ff > MAX_CH5) ? MAX_CH5 : pulse_cnt_ff;

   // locked frame with at least one channel closes at this gap
   assign emit = accept & is_gap & in_frame_ff & same_len &
                 (pulse_cnt_ff >= min_chans_ff) & (match_ff >= lock_frames_ff) &
                 (pulse_cnt_ff != 5'd0);

   // pulse inside an open frame goes to the store unless the store is full
   assign store_wr = accept & ~is_gap & is_pulse & in_frame_ff & (pulse_cnt_ff < MAX_CH5);

   assign slot_free = ~rsp_tvalid | rsp_tready;
   assign last_chan = ((5'(rd_ptr_ff) + 5'd1) == deliver_cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppm_pkg::ST_IDLE: if (emit) state_in = ppm_pkg::ST_LOAD;
         ppm_pkg::ST_LOAD: if (slot_free && last_chan) state_in = ppm_pkg::ST_IDLE;
         default:          state_in = ppm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      load       = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         ppm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_en      = emit;   // first entry read along with the gap
         end
         ppm_pkg::ST_LOAD: begin
            load    = slot_free;
            rd_en   = slot_free & ~last_chan;
            rd_addr = rd_ptr_ff + AW'(1);
         end
         default: ;
      endcase
   end

   // frame bookkeeping on each accepted interval
   always_comb begin
      in_frame_in    = in_frame_ff;
      pulse_cnt_in   = pulse_cnt_ff;
      prev_cnt_in    = prev_cnt_ff;
      match_in       = match_ff;
      deliver_cnt_in = deliver_cnt_ff;
      rd_ptr_in      = rd_ptr_ff;
      if (accept) begin
         if (is_gap) begin
            if (in_frame_ff) begin
               if (same_len) begin
                  if ((pulse_cnt_ff >= min_chans_ff) && (match_ff < lock_frames_ff))
                     match_in = match_ff + 4'd1;
               end else begin
                  match_in = 4'd0;
               end
               prev_cnt_in = pulse_cnt_ff;
            end else begin
               in_frame_in = 1'b1;
            end
            pulse_cnt_in = 5'd0;
         end else if (is_pulse) begin
            if (in_frame_ff) pulse_cnt_in = pulse_cnt_ff + 5'd1;
         end else begin
            in_frame_in = 1'b0;   // bad interval or too many pulses: sync lost
         end
      end
      if (emit) begin
         deliver_cnt_in = clamp_cnt;
         rd_ptr_in      = '0;
      end else if (rd_en) begin
         rd_ptr_in = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ppm_pkg::ST_IDLE;
         in_frame_ff    <= 1'b0;
         pulse_cnt_ff   <= 5'd0;
         prev_cnt_ff    <= 5'd0;
         match_ff       <= 4'd0;
         deliver_cnt_ff <= 5'd0;
         rd_ptr_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         in_frame_ff    <= in_frame_in;
         pulse_cnt_ff   <= pulse_cnt_in;
         prev_cnt_ff    <= prev_cnt_in;
         match_ff       <= match_in;
         deliver_cnt_ff <= deliver_cnt_in;
         rd_ptr_ff      <= rd_ptr_in;
      end
   end

   // ---------------------------------------------------------------
   // channel store: one write port (pulses), one registered read port
   // (readout); writes only happen in idle, reads at a gap or in load,
   // so the two never touch an entry in the same cycle
   // ---------------------------------------------------------------
   logic [15:0] chan_mem [MAX_CHANNELS];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_wr) chan_mem[pulse_cnt_ff[AW-1:0]] <= interval;
      if (rd_en)    rd_data_ff <= chan_mem[rd_addr];
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic        rsp_valid_ff;
   logic [3:0]  rsp_index_ff, rsp_count_ff;
   logic [15:0] rsp_width_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_index_ff <= 4'(rd_ptr_ff);
         rsp_width_ff <= rd_data_ff;
         rsp_count_ff <= deliver_cnt_ff[3:0];
         rsp_last_ff  <= last_chan;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_width_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: dv/ppm_frame_decoder_tb.sv
// testbench of the ppm frame decoder: predicted channel readout checked under random traffic
module ppm_frame_decoder_tb;

   localparam int MAX_CH = ppm_pkg::MAX_CHANNELS_DEFAULT;
   // quiet cycles allowed before a register write or the end: one full readout and margin
   localparam int SETTLE_CYCLES = 2 * MAX_CH + 8;
   // cycles with no transfer at all before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // register slots past the end of the map, writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [3:0]  index;
      logic [15:0] width;
      logic [3:0]  count;
      logic        last;
   } channel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ppm_frame_decoder #(
      .MAX_CHANNELS(MAX_CH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // intervals waiting to be sent, channels waiting to come back
   logic [15:0] interval_q[$];
   channel_type expected_channels[$];

   // predictor copy of the registers
   logic [15:0] gap_limit;
   logic [15:0] pulse_lo;
   logic [15:0] pulse_hi;
   logic [3:0]  lock_target;
   logic [4:0]  min_chans;
   logic [4:0]  max_pulses;
   // predictor copy of the decoder state
   logic        accumulating;
   logic [4:0]  pulse_tally;
   logic [4:0]  prior_tally;
   logic [3:0]  match_tally;
   logic [15:0] width_store[MAX_CH];

   // settings the traffic generator shapes its frames around
   int cfg_gap, cfg_pmin, cfg_pmax;

   bit req_taken;        // req transfer seen at the last rising edge
   bit calm;             // no idling on either side once set
   int req_gap_left;
   int rsp_stall_left;
   int quiet_cycles;
   int errors;
   int intervals_sent;
   int channels_seen;
   int frames_seen;
   int settings_used;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 100)
         $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   // advance the predictor by one interval, queue any channels a locked frame releases
   task automatic predict_interval(input logic [15:0] iv);
      int n;
      channel_type c;
      if (iv >= gap_limit) begin
         if (accumulating) begin
            if (pulse_tally == prior_tally) begin
               if (pulse_tally >= min_chans) begin
                  if (match_tally < lock_target) begin
                     match_tally = match_tally + 4'd1;
                  end else begin
                     // long frames are cut down to the store size
                     n = (pulse_tally > MAX_CH) ? MAX_CH : pulse_tally;
                     for (int k = 0; k < n; k++) begin
                        c.index = 4'(k);
                        c.width = width_store[k];
                        c.count = 4'(n);
                        c.last  = (k + 1 == n);
                        expected_channels.push_back(c);
                     end
                  end
               end
            end else begin
               match_tally = '0;
            end
            prior_tally = pulse_tally;
         end else begin
            // a gap outside a frame opens one, lock progress is kept
            accumulating = 1'b1;
         end
         pulse_tally = '0;
      end else if (pulse_tally < max_pulses && iv >= pulse_lo && iv <= pulse_hi) begin
         // pulses outside a frame are ignored
         if (accumulating) begin
            if (pulse_tally < MAX_CH)
               width_store[pulse_tally] = iv;
            pulse_tally = pulse_tally + 5'd1;
         end
      end else begin
         // bad interval or pulse overflow drops sync, tally kept until the next gap
         accumulating = 1'b0;
      end
   endtask

   task automatic apply_register(input logic [4:0] addr, input logic [31:0] data);
      case (addr[4:2])
         ppm_pkg::REG_FRAME_GAP_MIN:   gap_limit   = data[15:0];
         ppm_pkg::REG_PULSE_MIN:       pulse_lo    = data[15:0];
         ppm_pkg::REG_PULSE_MAX:       pulse_hi    = data[15:0];
         ppm_pkg::REG_LOCK_FRAMES:     lock_target = data[3:0];
         ppm_pkg::REG_MIN_FRAME_CHANS: min_chans   = data[4:0];
         ppm_pkg::REG_MAX_FRAME_PULSE: max_pulses  = data[4:0];
         default: ;
      endcase
   endtask

   task automatic check_channel(input channel_type got);
      channel_type want;
      if (expected_channels.size() == 0) begin
         report_mismatch("channel transfer with none pending, chan_index", got.index, 0);
         return;
      end
      want = expected_channels.pop_front();
      if (got.index != want.index)
         report_mismatch("chan_index", got.index, want.index);
      if (got.width != want.width)
         report_mismatch("chan_width_us", got.width, want.width);
      if (got.count != want.count)
         report_mismatch("frame_channels", got.count, want.count);
      if (got.last != want.last)
         report_mismatch("last_in_frame", got.last, want.last);
   endtask

   // monitor: everything is sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         gap_limit    = ppm_pkg::FRAME_GAP_MIN_RST;
         pulse_lo     = ppm_pkg::PULSE_MIN_RST;
         pulse_hi     = ppm_pkg::PULSE_MAX_RST;
         lock_target  = ppm_pkg::LOCK_FRAMES_RST;
         min_chans    = ppm_pkg::MIN_FRAME_CHANS_RST;
         max_pulses   = ppm_pkg::MAX_FRAME_PULSE_RST;
         accumulating = 1'b0;
         pulse_tally  = '0;
         prior_tally  = '0;
         match_tally  = '0;
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predict_interval(req_tdata);
            intervals_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_channel({rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[23:20], rsp_tlast});
            channels_seen++;
            if (rsp_tlast)
               frames_seen++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_register(csr_paddr, csr_pwdata);
         // watchdog bookkeeping: any transfer on any port counts as progress
         if (req_taken || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // interval driver: holds an item until its transfer, idles in random bursts
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (interval_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            req_gap_left = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else begin
            req_tdata  <= interval_q.pop_front();
            req_tvalid <= 1'b1;
         end
      end
   end

   // result side backpressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one apb transfer: setup cycle, then access until pready
   task automatic csr_access(input bit is_write, input logic [2:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // junk above the register width checks that the block masks it off
   task automatic write_register(input logic [2:0] idx, input int value, input logic [31:0] mask);
      logic [31:0] unused;
      csr_access(1'b1, idx, ($urandom & ~mask) | (value & mask), unused);
   endtask

   task automatic verify_register(input logic [2:0] idx, input int value, input logic [31:0] mask);
      logic [31:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if ((rdata & mask) != (value & mask))
         report_mismatch($sformatf("read back of register %0d", idx), rdata & mask, value & mask);
   endtask

   // only called with the decoder idle
   task automatic program_registers(input int gap, input int pmin, input int pmax,
                                    input int lock, input int minch, input int maxp);
      cfg_gap  = gap;
      cfg_pmin = pmin;
      cfg_pmax = pmax;
      write_register(ppm_pkg::REG_FRAME_GAP_MIN, gap, 32'hFFFF);
      write_register(ppm_pkg::REG_PULSE_MIN, pmin, 32'hFFFF);
      write_register(ppm_pkg::REG_PULSE_MAX, pmax, 32'hFFFF);
      write_register(ppm_pkg::REG_LOCK_FRAMES, lock, 32'hF);
      write_register(ppm_pkg::REG_MIN_FRAME_CHANS, minch, 32'h1F);
      write_register(ppm_pkg::REG_MAX_FRAME_PULSE, maxp, 32'h1F);
      // slots past the map must not disturb anything
      write_register(REG_SPARE_LO, $urandom, 32'h0);
      write_register(REG_SPARE_HI, $urandom, 32'h0);
      verify_register(ppm_pkg::REG_FRAME_GAP_MIN, gap, 32'hFFFF);
      verify_register(ppm_pkg::REG_PULSE_MIN, pmin, 32'hFFFF);
      verify_register(ppm_pkg::REG_PULSE_MAX, pmax, 32'hFFFF);
      verify_register(ppm_pkg::REG_LOCK_FRAMES, lock, 32'hF);
      verify_register(ppm_pkg::REG_MIN_FRAME_CHANS, minch, 32'h1F);
      verify_register(ppm_pkg::REG_MAX_FRAME_PULSE, maxp, 32'h1F);
      settings_used++;
      @(posedge clock);
   endtask

   // sender holds off until every predicted channel is back, then lets the readout settle
   task automatic drain();
      while (interval_q.size() != 0 || req_tvalid || expected_channels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed frames whose length sticks for a while so lock is reached,
   // with some raw noise and the odd bad pulse inside a frame
   task automatic queue_traffic(input int count, input int long_len);
      int pushed;
      int nch;
      int hi;
      bit pulses_ok;
      pushed = 0;
      nch = $urandom_range(1, 8);
      hi = cfg_pmax;
      if (cfg_gap > 0 && hi >= cfg_gap)
         hi = cfg_gap - 1;
      pulses_ok = (cfg_pmin <= hi);
      while (pushed < count) begin
         if ($urandom_range(0, 99) < 8) begin
            interval_q.push_back(16'($urandom));
            pushed++;
         end else begin
            if ($urandom_range(0, 4) == 0)
               nch = ($urandom_range(0, 9) < 6) ? $urandom_range(0, MAX_CH)
                                                : $urandom_range(MAX_CH, long_len);
            interval_q.push_back(16'($urandom_range(cfg_gap, 65535)));
            for (int k = 0; k < nch; k++) begin
               if (!pulses_ok || $urandom_range(0, 49) == 0)
                  interval_q.push_back(16'($urandom));
               else
                  interval_q.push_back(16'($urandom_range(cfg_pmin, hi)));
            end
            pushed += nch + 1;
         end
      end
   endtask

   // hang detector
   initial begin
      wait (!reset);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("ppm_frame_decoder_tb: done, errors");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: immediate lock so short frames deliver at once
      program_registers(2900, 800, 2500, 0, 0, 20);
      interval_q = '{
         16'd1000,                        // pulse before any gap, ignored
         16'd0,                           // bad interval outside a frame
         16'd65535,                       // gap opens a frame
         16'd2900,                        // empty frame closes, nothing delivered
         16'd800, 16'd2500,               // window edges
         16'd2899,                        // just under the gap, drops sync
         16'd2900,                        // gap outside a frame reopens
         16'd1234, 16'd2500,
         16'd65535,                       // length differs, match resets
         16'd800, 16'd801,
         16'd3000,                        // equal length, two channels out
         16'd2000, 16'd2000, 16'd2000,
         16'd2900,                        // longer frame, mismatch
         16'd1500, 16'd1600, 16'd1700,
         16'd65535                        // three channels out
      };
      drain();

      // reset values
      program_registers(2900, 800, 2500, 4, 4, 20);
      queue_traffic(55, 14);
      drain();

      // long frames and pulse overflow, with a full hold-off in the middle
      program_registers(3000, 900, 2100, 1, 2, 16);
      queue_traffic(30, 20);
      drain();
      queue_traffic(30, 20);
      drain();

      // widest window, slowest lock
      program_registers(65535, 0, 65535, 15, 0, 31);
      queue_traffic(45, 14);
      drain();

      // every interval is a gap
      program_registers(0, 500, 1500, 0, 3, 8);
      queue_traffic(15, 12);
      drain();

      // window out of order, no interval is a pulse
      program_registers(20000, 65535, 0, 2, 3, 5);
      queue_traffic(25, 12);
      drain();

      // no pulse allowed at all
      program_registers(1500, 100, 1400, 0, 0, 0);
      queue_traffic(25, 12);
      drain();

      // only frames of 31 pulses count
      program_registers(4000, 1000, 2000, 0, 31, 31);
      queue_traffic(40, 31);
      drain();

      // final stretch without idling
      calm = 1'b1;
      program_registers(2900, 800, 2500, 0, 1, 20);
      queue_traffic(40, 12);
      drain();

      $display("ppm_frame_decoder_tb: %0d intervals sent under %0d register settings",
               intervals_sent, settings_used);
      $display("ppm_frame_decoder_tb: %0d channels checked in %0d delivered frames",
               channels_seen, frames_seen);
      if (errors == 0)
         $display("ppm_frame_decoder_tb: done, clean");
      else
         $display("ppm_frame_decoder_tb: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
sv/ppm_pkg.sv
sv/ppm_frame_decoder.sv
dv/ppm_frame_decoder_tb.sv
